/* rtl/bcv_pkg.sv */
`default_nettype none

package bcv_pkg;

   // request type words
   localparam logic [31:0] TYPE_READ      = 32'd0;
   localparam logic [31:0] TYPE_WRITE     = 32'd1;
   localparam logic [31:0] TYPE_FLUSH     = 32'd4;
   localparam logic [31:0] TYPE_FLUSH_OUT = 32'd5;
   localparam logic [31:0] TYPE_IDENT     = 32'd8;
   localparam logic [31:0] TYPE_DISCARD   = 32'd11;
   localparam logic [31:0] BARRIER_BIT    = 32'h8000_0000;

   localparam logic [31:0] HEADER_BYTES = 32'd16;
   localparam logic [31:0] STATUS_BYTES = 32'd1;
   localparam int          SECTOR_SHIFT = 9;

   // result actions
   localparam logic [1:0] ACT_ABORT    = 2'd0;
   localparam logic [1:0] ACT_COMPLETE = 2'd1;
   localparam logic [1:0] ACT_DISPATCH = 2'd2;

   // completion status
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_IOERR  = 2'd1;
   localparam logic [1:0] ST_UNSUPP = 2'd2;

   // operation codes
   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_DISCARD = 3'd2;
   localparam logic [2:0] OP_FLUSH   = 3'd3;
   localparam logic [2:0] OP_IDENT   = 3'd4;
   localparam logic [2:0] OP_OTHER   = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_READ_ONLY = 2'd1;
   localparam logic [1:0] CSR_BACKEND  = 2'd2;

   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int BYTES_W     = 38;
   localparam int SEG_COUNT_W = 7;

   typedef struct packed {
      logic [31:0] desc_len;
      logic        device_writes;
      logic        last;
      logic [31:0] req_type;
      logic [63:0] req_sector;
   } bcv_item_type;

   typedef struct packed {
      logic [1:0]             action;
      logic [1:0]             status;
      logic [2:0]             operation;
      logic [63:0]            start_sector;
      logic [BYTES_W-1:0]     total_bytes;
      logic [SEG_COUNT_W-1:0] segment_count;
   } bcv_result_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] capacity_sectors;
      logic                  read_only;
      logic                  backend_present;
   } bcv_cfg_type;

   function automatic logic [2:0] op_code(input logic [31:0] t);
      case (t)
         TYPE_READ:      op_code = OP_READ;
         TYPE_WRITE:     op_code = OP_WRITE;
         TYPE_DISCARD:   op_code = OP_DISCARD;
         TYPE_FLUSH:     op_code = OP_FLUSH;
         TYPE_FLUSH_OUT: op_code = OP_FLUSH;
         TYPE_IDENT:     op_code = OP_IDENT;
         default:        op_code = OP_OTHER;
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/block_request_chain_validator_top.sv */
`default_nettype none

// Block request chain validator. Descriptors of a block request chain enter
// one per item on the req_ channel: header first, then data segments, then
// the status descriptor with req_last set. Exactly one result leaves on the
// rsp_ channel per chain, for the descriptor marked last: abort, complete with
// a status, or dispatch, with operation, sector, byte total and segment count.
// A descriptor is taken every cycle but for the stall below; a result shows
// on rsp_valid after its last descriptor has passed the input register, then
// the result register. A last descriptor waits in the input register only
// while the result register is full and rsp_ready is low, and that stalls the
// input. The csr_ port sets capacity, read-only and backend presence; it is to
// be written only while no chain is in flight; the block does not enforce it.
module block_request_chain_validator_top #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [31:0]                         req_desc_len,
   input  wire logic                                req_device_writes,
   input  wire logic                                req_last,
   input  wire logic [31:0]                         req_req_type,
   input  wire logic [63:0]                         req_req_sector,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_action,
   output logic [1:0]                               rsp_status,
   output logic [2:0]                               rsp_operation,
   output logic [63:0]                              rsp_start_sector,
   output logic [bcv_pkg::BYTES_W-1:0]              rsp_total_bytes,
   output logic [bcv_pkg::SEG_COUNT_W-1:0]          rsp_segment_count,

   input  wire logic                                csr_write_en,
   input  wire logic [bcv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bcv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bcv_pkg::*;

   bcv_cfg_type    cfg_ff, cfg_in;
   logic           in_valid_ff, in_valid_in;
   bcv_item_type   in_item_ff, in_item_in;
   logic           step;
   logic           can_load;
   bcv_result_type result;
   bcv_result_type rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CAPACITY:  cfg_in.capacity_sectors = csr_wdata;
            CSR_READ_ONLY: cfg_in.read_only        = csr_wdata[0];
            CSR_BACKEND:   cfg_in.backend_present  = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // only a last descriptor needs room in the result register
   assign step      = in_valid_ff && (!in_item_ff.last || can_load);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = '{desc_len:      req_desc_len,
                         device_writes: req_device_writes,
                         last:          req_last,
                         req_type:      req_req_type,
                         req_sector:    req_req_sector};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   bcv_chain #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   bcv_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step && in_item_ff.last),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_action        = rsp_data.action;
   assign rsp_status        = rsp_data.status;
   assign rsp_operation     = rsp_data.operation;
   assign rsp_start_sector  = rsp_data.start_sector;
   assign rsp_total_bytes   = rsp_data.total_bytes;
   assign rsp_segment_count = rsp_data.segment_count;

endmodule

`default_nettype wire

/* rtl/bcv_chain.sv */
`default_nettype none

module bcv_chain #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire bcv_pkg::bcv_item_type   item,
   input  wire bcv_pkg::bcv_cfg_type    cfg,
   output bcv_pkg::bcv_result_type      result
);
   import bcv_pkg::*;

   localparam int POS_W = $clog2(MAX_SEGMENTS + 3);
   localparam logic [POS_W-1:0] SEG_LIMIT = POS_W'(MAX_SEGMENTS);
   localparam logic [POS_W-1:0] POS_SAT   = POS_W'(MAX_SEGMENTS + 2);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [31:0]        held_type_ff, held_type_in;
   logic [63:0]        held_sector_ff, held_sector_in;
   logic [BYTES_W-1:0] byte_total_ff, byte_total_in;
   logic               header_bad_ff, header_bad_in;
   logic               conflict_ff, conflict_in;

   logic [31:0]        type_masked;
   logic               wop;
   logic [POS_W-1:0]   segs;
   logic               chain_bad;
   logic [64:0]        end_sector;
   logic               range_bad;
   logic               ioerr;
   logic [2:0]         op;

   assign type_masked = held_type_ff & ~BARRIER_BIT;
   assign wop  = (type_masked == TYPE_WRITE) || (type_masked == TYPE_DISCARD);
   assign segs = pos_ff - POS_W'(1);
   assign op   = op_code(type_masked);

   assign chain_bad = (segs > SEG_LIMIT) || header_bad_ff ||
                      (item.desc_len != STATUS_BYTES) || !item.device_writes;

   // sector plus whole sectors of data, kept one bit wider so it cannot wrap
   assign end_sector = {1'b0, held_sector_ff} +
                       65'(byte_total_ff[BYTES_W-1:SECTOR_SHIFT]);
   assign range_bad  = (byte_total_ff[SECTOR_SHIFT-1:0] != '0) ||
                       (end_sector > {17'd0, cfg.capacity_sectors});

   assign ioerr = !cfg.backend_present || (wop && cfg.read_only) || conflict_ff;

   always_comb begin
      result = '0;
      if ((pos_ff != '0) && !chain_bad) begin
         result.operation     = op;
         result.start_sector  = held_sector_ff;
         result.total_bytes   = byte_total_ff;
         result.segment_count = SEG_COUNT_W'(segs);
         if (ioerr) begin
            result.action = ACT_COMPLETE;
            result.status = ST_IOERR;
         end else begin
            case (type_masked)
               TYPE_READ, TYPE_WRITE: begin
                  if (range_bad) begin
                     result.action = ACT_COMPLETE;
                     result.status = ST_IOERR;
                  end else begin
                     result.action = ACT_DISPATCH;
                  end
               end
               TYPE_DISCARD, TYPE_FLUSH, TYPE_FLUSH_OUT: begin
                  result.action = ACT_DISPATCH;
               end
               TYPE_IDENT: begin
                  result.action = ACT_COMPLETE;
                  result.status = ST_OK;
               end
               default: begin
                  result.action = ACT_COMPLETE;
                  result.status = ST_UNSUPP;
               end
            endcase
         end
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      held_type_in   = held_type_ff;
      held_sector_in = held_sector_ff;
      byte_total_in  = byte_total_ff;
      header_bad_in  = header_bad_ff;
      conflict_in    = conflict_ff;
      if (step) begin
         if (pos_ff == '0) begin
            held_type_in   = item.req_type;
            held_sector_in = item.req_sector;
            header_bad_in  = item.device_writes || (item.desc_len != HEADER_BYTES);
            if (item.last) begin
               header_bad_in = 1'b0;
            end else begin
               pos_in = POS_W'(1);
            end
         end else if (!item.last) begin
            // segments past the limit are counted but not accumulated
            if (pos_ff <= SEG_LIMIT) begin
               byte_total_in = byte_total_ff + BYTES_W'(item.desc_len);
               if (!item.device_writes != wop) begin
                  conflict_in = 1'b1;
               end
            end
            if (pos_ff < POS_SAT) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            pos_in        = '0;
            byte_total_in = '0;
            header_bad_in = 1'b0;
            conflict_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         byte_total_ff <= '0;
         header_bad_ff <= 1'b0;
         conflict_ff   <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         byte_total_ff <= byte_total_in;
         header_bad_ff <= header_bad_in;
         conflict_ff   <= conflict_in;
      end
   end

   always_ff @(posedge clock) begin
      held_type_ff   <= held_type_in;
      held_sector_ff <= held_sector_in;
   end

endmodule

`default_nettype wire

/* rtl/bcv_rsp_reg.sv */
`default_nettype none

module bcv_rsp_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire bcv_pkg::bcv_result_type  result,
   output logic                          can_load,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output bcv_pkg::bcv_result_type       rsp_data
);
   import bcv_pkg::*;

   logic           valid_ff, valid_in;
   bcv_result_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/bcv_checker.sv */
`default_nettype none

module bcv_checker #(
   parameter int MAX_SEGMENTS = 64
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [1:0]                          rsp_action,
   input wire logic [1:0]                          rsp_status,
   input wire logic [2:0]                          rsp_operation,
   input wire logic [63:0]                         rsp_start_sector,
   input wire logic [bcv_pkg::BYTES_W-1:0]         rsp_total_bytes,
   input wire logic [bcv_pkg::SEG_COUNT_W-1:0]     rsp_segment_count
);
   import bcv_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_status) && $stable(rsp_start_sector) &&
      $stable(rsp_total_bytes) && $stable(rsp_segment_count))
      else $error("rsp item changed while stalled");

   // an aborted chain carries no details
   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_ABORT |->
      rsp_status == ST_OK && rsp_operation == OP_READ &&
      rsp_start_sector == '0 && rsp_total_bytes == '0 && rsp_segment_count == '0)
      else $error("abort item with nonzero fields");

   a_status_only_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_COMPLETE |-> rsp_status == ST_OK)
      else $error("status set on a non-complete item");

   a_dispatch_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_DISPATCH |->
      rsp_operation == OP_READ || rsp_operation == OP_WRITE ||
      rsp_operation == OP_DISCARD || rsp_operation == OP_FLUSH)
      else $error("dispatch of an operation the backend does not take");

   a_seg_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_ABORT |->
      rsp_segment_count <= SEG_COUNT_W'(MAX_SEGMENTS))
      else $error("accepted chain exceeds segment limit");

endmodule

bind block_request_chain_validator_top bcv_checker #(
   .MAX_SEGMENTS(MAX_SEGMENTS)
) u_bcv_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_action        (rsp_action),
   .rsp_status        (rsp_status),
   .rsp_operation     (rsp_operation),
   .rsp_start_sector  (rsp_start_sector),
   .rsp_total_bytes   (rsp_total_bytes),
   .rsp_segment_count (rsp_segment_count)
);

`default_nettype wire

/* verif/block_request_chain_validator_top_tb.sv */
`default_nettype none

module block_request_chain_validator_top_tb;
   import bcv_pkg::*;

   localparam int MAX_SEGS = 64;

   // expected results of the chains, kept in step with the accepted descriptors
   class chain_scoreboard;
      logic [CSR_DATA_W-1:0] capacity = '0;
      logic                  ro = 1'b0;
      logic                  backend = 1'b0;
      int unsigned           pos = 0;
      logic [31:0]           held_type = '0;
      logic [63:0]           held_sector = '0;
      logic [BYTES_W-1:0]    byte_sum = '0;
      logic                  hdr_bad = 1'b0;
      logic                  dir_conflict = 1'b0;
      bcv_result_type        outcome_q[$];
      int unsigned           errors = 0;

      function void clear_chain();
         pos = 0;
         held_type = '0;
         held_sector = '0;
         byte_sum = '0;
         hdr_bad = 1'b0;
         dir_conflict = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CAPACITY:  capacity = data;
            CSR_READ_ONLY: ro = data[0];
            CSR_BACKEND:   backend = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      function void note_item(bcv_item_type it);
         logic [31:0]    typ;
         logic           wop;
         int unsigned    segs;
         bcv_result_type r;
         logic [63:0]    cap64;
         r = '0;
         if (pos == 0) begin
            held_type = it.req_type;
            held_sector = it.req_sector;
            hdr_bad = it.device_writes || (it.desc_len != HEADER_BYTES);
            if (it.last) begin
               // header alone
               clear_chain();
               outcome_q.push_back(r);
            end else begin
               pos = 1;
            end
            return;
         end
         typ = held_type & ~BARRIER_BIT;
         wop = (typ == TYPE_WRITE) || (typ == TYPE_DISCARD);
         if (!it.last) begin
            // segments past the limit are counted but not summed
            if (pos < MAX_SEGS + 1) begin
               byte_sum = byte_sum + it.desc_len;
               if ((it.device_writes == 1'b0) != wop)
                  dir_conflict = 1'b1;
            end
            if (pos < MAX_SEGS + 2)
               pos++;
            return;
         end
         segs = pos - 1;
         if (segs > MAX_SEGS || hdr_bad || it.desc_len != STATUS_BYTES || !it.device_writes) begin
            clear_chain();
            outcome_q.push_back(r);
            return;
         end
         case (typ)
            TYPE_READ:                 r.operation = OP_READ;
            TYPE_WRITE:                r.operation = OP_WRITE;
            TYPE_DISCARD:              r.operation = OP_DISCARD;
            TYPE_FLUSH, TYPE_FLUSH_OUT: r.operation = OP_FLUSH;
            TYPE_IDENT:                r.operation = OP_IDENT;
            default:                   r.operation = OP_OTHER;
         endcase
         r.start_sector = held_sector;
         r.total_bytes = byte_sum;
         r.segment_count = 7'(segs);
         cap64 = 64'(capacity);
         if (!backend || (wop && ro) || dir_conflict) begin
            r.action = ACT_COMPLETE;
            r.status = ST_IOERR;
         end else begin
            case (typ)
               TYPE_READ, TYPE_WRITE: begin
                  // capacity bound compared without wrap
                  if (byte_sum[SECTOR_SHIFT-1:0] != '0 || held_sector > cap64 ||
                      64'(byte_sum >> SECTOR_SHIFT) > cap64 - held_sector) begin
                     r.action = ACT_COMPLETE;
                     r.status = ST_IOERR;
                  end else begin
                     r.action = ACT_DISPATCH;
                  end
               end
               TYPE_DISCARD, TYPE_FLUSH, TYPE_FLUSH_OUT: r.action = ACT_DISPATCH;
               TYPE_IDENT: begin
                  r.action = ACT_COMPLETE;
                  r.status = ST_OK;
               end
               default: begin
                  r.action = ACT_COMPLETE;
                  r.status = ST_UNSUPP;
               end
            endcase
         end
         clear_chain();
         outcome_q.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(bcv_result_type got);
         bcv_result_type want;
         if (outcome_q.size() == 0) begin
            $display("%0t: result with nothing pending, actual %0h", $time, got);
            errors++;
            return;
         end
         want = outcome_q.pop_front();
         check_field("action", 64'(want.action), 64'(got.action));
         check_field("status", 64'(want.status), 64'(got.status));
         check_field("operation", 64'(want.operation), 64'(got.operation));
         check_field("start_sector", want.start_sector, got.start_sector);
         check_field("total_bytes", 64'(want.total_bytes), 64'(got.total_bytes));
         check_field("segment_count", 64'(want.segment_count), 64'(got.segment_count));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [31:0]              req_desc_len = '0;
   logic                     req_device_writes = 1'b0;
   logic                     req_last = 1'b0;
   logic [31:0]              req_req_type = '0;
   logic [63:0]              req_req_sector = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_action;
   logic [1:0]               rsp_status;
   logic [2:0]               rsp_operation;
   logic [63:0]              rsp_start_sector;
   logic [BYTES_W-1:0]       rsp_total_bytes;
   logic [SEG_COUNT_W-1:0]   rsp_segment_count;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   chain_scoreboard          sb;
   int unsigned              items_sent = 0;
   int unsigned              burst_left = 0;
   int unsigned              max_gap = 8;
   int unsigned              rsp_mode = 0;
   bit                       long_hold = 1'b0;
   logic [CSR_DATA_W-1:0]    cur_cap = '0;

   block_request_chain_validator_top #(.MAX_SEGMENTS(MAX_SEGS)) uut (.*);

   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic bcv_item_type desc(logic [31:0] len, logic dw, logic lst,
                                         logic [31:0] typ, logic [63:0] sec);
      bcv_item_type it;
      it.desc_len = len;
      it.device_writes = dw;
      it.last = lst;
      it.req_type = typ;
      it.req_sector = sec;
      return it;
   endfunction

   // bursts of random length, random gaps in between
   task automatic send_item(input bcv_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_desc_len <= it.desc_len;
      req_device_writes <= it.device_writes;
      req_last <= it.last;
      req_req_type <= it.req_type;
      req_req_sector <= it.req_sector;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic std_chain(input logic [31:0] typ, input logic [63:0] sec,
                            input int unsigned nsegs, input logic [31:0] seg_len,
                            input logic seg_dw, input logic [31:0] hdr_len, input logic st_dw);
      send_item(desc(hdr_len, 1'b0, 1'b0, typ, sec));
      repeat (nsegs) send_item(desc(seg_len, seg_dw, 1'b0, $urandom, rnd64()));
      send_item(desc(STATUS_BYTES, st_dw, 1'b1, $urandom, rnd64()));
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] cap, input logic ro, input logic bp);
      logic [63:0] noise;
      csr_write_en <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      sb.write_reg(CSR_CAPACITY, cap);
      noise = rnd64();
      csr_index <= CSR_READ_ONLY;
      csr_wdata <= {noise[CSR_DATA_W-2:0], ro};
      @(posedge clock);
      sb.write_reg(CSR_READ_ONLY, {noise[CSR_DATA_W-2:0], ro});
      noise = rnd64();
      csr_index <= CSR_BACKEND;
      csr_wdata <= {noise[CSR_DATA_W-2:0], bp};
      @(posedge clock);
      sb.write_reg(CSR_BACKEND, {noise[CSR_DATA_W-2:0], bp});
      csr_write_en <= 1'b0;
      cur_cap = cap;
   endtask

   // mostly well-formed chains, some with a broken header, status or direction
   task automatic random_chain();
      logic [31:0]  typ, plain, len, hdr_len;
      logic [63:0]  sec, sum, q;
      logic         wop, seg_dw, bad_dir, hdr_dw, st_dw;
      int unsigned  nsegs, len_mode, pick;
      bcv_item_type seg_q[$];
      case ($urandom_range(0, 9))
         0, 1:    typ = TYPE_READ;
         2, 3:    typ = TYPE_WRITE;
         4:       typ = TYPE_DISCARD;
         5:       typ = TYPE_FLUSH;
         6:       typ = TYPE_FLUSH_OUT;
         7:       typ = TYPE_IDENT;
         8:       typ = $urandom;
         default: typ = $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 3) == 0)
         typ = typ | BARRIER_BIT;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_item(desc($urandom, 1'($urandom_range(0, 1)), 1'b1, typ, rnd64()));
         return;
      end
      plain = typ & ~BARRIER_BIT;
      wop = (plain == TYPE_WRITE) || (plain == TYPE_DISCARD);
      pick = $urandom_range(0, 99);
      if (pick < 90)      nsegs = $urandom_range(0, 4);
      else if (pick < 96) nsegs = $urandom_range(5, 16);
      else if (pick < 98) nsegs = $urandom_range(60, MAX_SEGS);
      else                nsegs = $urandom_range(MAX_SEGS + 1, MAX_SEGS + 6);
      len_mode = $urandom_range(0, 9);
      bad_dir = ($urandom_range(0, 9) == 0);
      sum = '0;
      for (int i = 0; i < nsegs; i++) begin
         case (len_mode)
            6:       len = $urandom_range(0, 1023);
            7:       len = $urandom;
            8:       len = 32'hFFFF_FFFF;
            9:       len = '0;
            default: len = 32'(512 * $urandom_range(0, 8));
         endcase
         seg_dw = !wop;
         if (bad_dir && $urandom_range(0, 2) == 0)
            seg_dw = wop;
         seg_q.push_back(desc(len, seg_dw, 1'b0, $urandom, rnd64()));
         sum += len;
      end
      q = sum >> SECTOR_SHIFT;
      case ($urandom_range(0, 7))
         0, 1, 2: sec = (q <= 64'(cur_cap)) ? 64'(cur_cap) - q : '0;
         3:       sec = 64'(cur_cap) - q + 1;
         4:       sec = rnd64();
         5:       sec = '1;
         6:       sec = '0;
         default: sec = rnd64() % (64'(cur_cap) + 1);
      endcase
      hdr_len = HEADER_BYTES;
      hdr_dw = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 3)      hdr_len = $urandom;
      else if (pick < 6) hdr_dw = 1'b1;
      send_item(desc(hdr_len, hdr_dw, 1'b0, typ, sec));
      foreach (seg_q[i]) send_item(seg_q[i]);
      len = STATUS_BYTES;
      st_dw = 1'b1;
      if ($urandom_range(0, 99) >= 92) begin
         len = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 2));
         st_dw = 1'($urandom_range(0, 1));
      end
      send_item(desc(len, st_dw, 1'b1, $urandom, rnd64()));
   endtask

   // receiver: stall pattern by mode, plus one long hold on request
   initial begin : receiver
      int unsigned tick;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            case (rsp_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ready <= ((tick % 7) < 4);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_result({rsp_action, rsp_status, rsp_operation, rsp_start_sector,
                          rsp_total_bytes, rsp_segment_count});
   end

   initial begin
      int unsigned            start;
      logic [CSR_DATA_W-1:0]  cap;
      logic                   ro, bp;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: no backend
      rsp_mode = 2;
      send_item(desc(HEADER_BYTES, 1'b0, 1'b1, TYPE_READ, '0));
      std_chain(TYPE_READ, '0, 1, 512, 1'b1, HEADER_BYTES, 1'b1);
      drain_and_settle();
      set_config(48'd1000, 1'b0, 1'b1);
      std_chain(TYPE_READ, 64'd998, 1, 1024, 1'b1, HEADER_BYTES, 1'b1);
      std_chain(TYPE_WRITE, 64'd999, 1, 1024, 1'b0, HEADER_BYTES, 1'b1);
      std_chain(TYPE_READ, '1, 1, 512, 1'b1, HEADER_BYTES, 1'b1);
      std_chain(TYPE_DISCARD | BARRIER_BIT, 64'd5, 1, 4096, 1'b0, HEADER_BYTES, 1'b1);
      std_chain(TYPE_FLUSH, '0, 0, 0, 1'b1, HEADER_BYTES, 1'b1);
      std_chain(TYPE_IDENT, '0, 1, 20, 1'b1, HEADER_BYTES, 1'b1);
      std_chain(32'hFFFF_FFFF, '1, 0, 0, 1'b0, HEADER_BYTES, 1'b1);
      std_chain(TYPE_READ, '0, 1, 512, 1'b1, 32'd15, 1'b1);
      std_chain(TYPE_WRITE, '0, 1, 512, 1'b0, HEADER_BYTES, 1'b0);
      std_chain(TYPE_READ, '0, 1, 32'hFFFF_FFFF, 1'b0, HEADER_BYTES, 1'b1);
      drain_and_settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin cap = '1;  ro = 1'b0; bp = 1'b1; end
            1: begin cap = '0;  ro = 1'b1; bp = 1'b1; end
            2: begin cap = 48'($urandom_range(0, 4096)); ro = 1'b0; bp = 1'b0; end
            3: begin cap = 48'(rnd64()); ro = 1'b0; bp = 1'b1; end
            default: begin
               case ($urandom_range(0, 3))
                  0:       cap = '0;
                  1:       cap = '1;
                  2:       cap = 48'($urandom_range(0, 4096));
                  default: cap = 48'(rnd64());
               endcase
               ro = 1'($urandom_range(0, 1));
               bp = ($urandom_range(0, 4) != 0);
            end
         endcase
         set_config(cap, ro, bp);
         rsp_mode = p % 4;
         max_gap = (p == 0 || p == 3 || p == 6) ? 0 : 8;
         // hold the receiver off while items keep coming, so the input stalls
         if (p == 3)
            long_hold = 1'b1;
         start = items_sent;
         while (items_sent - start < 205) random_chain();
         drain_and_settle();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
